FILE: hw/rtl/mspd_pkg.sv
package mspd_pkg;

    // Ring depths; both are powers of two so that pointers wrap by truncation.
    localparam int MAX_WINDOW = 64;
    localparam int MAX_HOLD   = 64;
    localparam int WIN_PTR_W  = $clog2(MAX_WINDOW);
    localparam int HOLD_PTR_W = $clog2(MAX_HOLD);

    // Field and register widths.
    localparam int BIN_W  = 16;
    localparam int DATA_W = 32;
    localparam int LEN_W  = 7;
    localparam int ADDR_W = 3;
    localparam int PDATA_W = 32;

    // Configuration register indexes and their reset values.
    localparam logic [ADDR_W-3:0] REG_WINDOW_LENGTH = 1'b0;
    localparam logic [ADDR_W-3:0] REG_HOLD_LENGTH   = 1'b1;
    localparam logic [LEN_W-1:0]  WINDOW_LENGTH_RST = LEN_W'(16);
    localparam logic [LEN_W-1:0]  HOLD_LENGTH_RST   = LEN_W'(8);

    // Legal ranges of the two lengths.
    localparam logic [LEN_W-1:0] WINDOW_MIN = LEN_W'(2);
    localparam logic [LEN_W-1:0] WINDOW_MAX = LEN_W'(MAX_WINDOW);
    localparam logic [LEN_W-1:0] HOLD_MIN   = LEN_W'(1);
    localparam logic [LEN_W-1:0] HOLD_MAX   = LEN_W'(MAX_HOLD);

    // One input item: a spectrum bin and the end-of-frame flag.
    typedef struct packed {
        logic [BIN_W-1:0] bin_value;
        logic             last_bin;
    } mspd_in_t;

    // One result item, produced once per frame.
    typedef struct packed {
        logic              peak_found;
        logic [DATA_W-1:0] peak_position;
        logic [DATA_W-1:0] window_sum;
    } mspd_out_t;

    // Saturate a length register into its legal range.
    function automatic logic [LEN_W-1:0] clamp_len(
        input logic [LEN_W-1:0] v,
        input logic [LEN_W-1:0] lo,
        input logic [LEN_W-1:0] hi
    );
        logic [LEN_W-1:0] r;
        if (v < lo) begin
            r = lo;
        end else if (v > hi) begin
            r = hi;
        end else begin
            r = v;
        end
        return r;
    endfunction

endpackage

FILE: hw/rtl/moving_sum_peak_detector.sv
// Moving-sum peak-hold detector.
// Bins of a spectrum frame enter on the s_ channel (valid/ready), one item per
// cycle; last_bin marks the end of a frame. Each frame produces exactly one
// item on the m_ channel carrying the moving sum over window_length-1 frames,
// a flag that a held maximum has now been confirmed as a peak, and the frame
// position of the most recent peak. Bins without last_bin produce nothing.
// Throughput is one item per cycle while results are taken, including back-to-back
// last bins. A frame result reaches m_valid through the input register and then
// the result register: the accepting edge loads the input register, and the frame
// step carries it into the result register. The ring reads are fetched ahead from
// the post-update pointers, which is what allows a frame step every cycle.
// window_length and hold_length must be written over APB only while idle; the
// block does not enforce it. Out-of-range values saturate into their legal ranges.
// Reset clears all control state at once; ring entries never written read as zero
// through per-entry valid bits, so no clearing pass is needed.
// When m_ready is low the result waits in its register; ordinary bins keep
// flowing, and a further last bin waits in the input register, which then
// holds s_ready low until the result is taken.
module moving_sum_peak_detector (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  mspd_pkg::mspd_in_t                s_data,
    output logic                              m_valid,
    input  logic                              m_ready,
    output mspd_pkg::mspd_out_t               m_data,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [mspd_pkg::ADDR_W-1:0]       paddr,
    input  logic [mspd_pkg::PDATA_W-1:0]      pwdata,
    output logic [mspd_pkg::PDATA_W-1:0]      prdata,
    output logic                              pready
);
    import mspd_pkg::*;

    // Configuration registers.
    logic [LEN_W-1:0] win_len_reg, win_len_next;
    logic [LEN_W-1:0] hold_len_reg, hold_len_next;
    logic             cfg_wr;

    // Input stage.
    logic              in_valid_reg;
    logic [DATA_W-1:0] in_total_reg;
    logic              in_last_reg;
    logic [DATA_W-1:0] frame_acc_reg;
    logic [DATA_W-1:0] acc_plus_bin;

    // Frame state.
    logic [DATA_W-1:0]     last_prefix_reg;
    logic [WIN_PTR_W-1:0]  pw_reg;
    logic [HOLD_PTR_W-1:0] hw_reg;
    logic [DATA_W-1:0]     best_reg;
    logic [LEN_W-1:0]      hcount_reg;
    logic [DATA_W-1:0]     frames_reg;
    logic [DATA_W-1:0]     peak_frame_reg;

    // Rings with per-entry valid bits and registered read ports.
    logic [DATA_W-1:0]     prefix_mem [MAX_WINDOW];
    logic [MAX_WINDOW-1:0] prefix_vld_reg;
    logic [DATA_W-1:0]     prefix_rd_reg;
    logic                  prefix_rd_vld_reg;
    logic [DATA_W-1:0]     hold_mem [MAX_HOLD];
    logic [MAX_HOLD-1:0]   hold_vld_reg;
    logic [DATA_W-1:0]     hold_rd_reg;
    logic                  hold_rd_vld_reg;

    // Output register.
    logic      out_valid_reg;
    mspd_out_t out_reg;

    // Handshake and frame step signals.
    logic out_free, consume, step, s_fire;

    logic [LEN_W-1:0]      w_cur, h_cur, w_nx, h_nx;
    logic [WIN_PTR_W-1:0]  new_pw, pw_next, prefix_raddr;
    logic [HOLD_PTR_W-1:0] new_hw, hw_next, hold_raddr;
    logic [DATA_W-1:0]     sum, oldest, wsum, best1, held, best_n, peak_n, offset;
    logic [LEN_W-1:0]      hc1, hc_n;
    logic                  gt, found;

    // The APB port is always ready; reads return the raw register value.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_comb begin
        case (paddr[ADDR_W-1:2])
            REG_WINDOW_LENGTH: prdata = PDATA_W'(win_len_reg);
            REG_HOLD_LENGTH:   prdata = PDATA_W'(hold_len_reg);
            default:           prdata = '0;
        endcase
    end

    always_comb begin
        win_len_next  = win_len_reg;
        hold_len_next = hold_len_reg;
        if (cfg_wr) begin
            case (paddr[ADDR_W-1:2])
                REG_WINDOW_LENGTH: win_len_next  = pwdata[LEN_W-1:0];
                REG_HOLD_LENGTH:   hold_len_next = pwdata[LEN_W-1:0];
                default: ;
            endcase
        end
    end

    // An item with a last bin needs a free result slot; other bins always move on.
    assign out_free = !out_valid_reg || m_ready;
    assign consume  = in_valid_reg && (!in_last_reg || out_free);
    assign step     = consume && in_last_reg;
    assign s_ready  = !in_valid_reg || consume;
    assign s_fire   = s_valid && s_ready;

    // The frame total is accumulated as bins are accepted.
    assign acc_plus_bin = frame_acc_reg + DATA_W'(s_data.bin_value);

    // Effective lengths, now and after this edge.
    assign w_cur = clamp_len(win_len_reg, WINDOW_MIN, WINDOW_MAX);
    assign h_cur = clamp_len(hold_len_reg, HOLD_MIN, HOLD_MAX);
    assign w_nx  = clamp_len(win_len_next, WINDOW_MIN, WINDOW_MAX);
    assign h_nx  = clamp_len(hold_len_next, HOLD_MIN, HOLD_MAX);

    // Frame step datapath.
    assign new_pw = pw_reg + WIN_PTR_W'(1);
    assign new_hw = hw_reg + HOLD_PTR_W'(1);
    assign sum    = last_prefix_reg + in_total_reg;
    assign oldest = prefix_rd_vld_reg ? prefix_rd_reg : '0;
    assign wsum   = sum - oldest;

    assign gt    = wsum > best_reg;
    assign best1 = gt ? wsum : best_reg;
    assign hc1   = gt ? h_cur : hcount_reg;

    // A hold length of one looks back at the entry written in this very frame.
    assign held = (h_cur == HOLD_MIN) ? wsum : (hold_rd_vld_reg ? hold_rd_reg : '0);

    assign offset = DATA_W'(h_cur) + DATA_W'(1) + DATA_W'(w_cur >> 1);

    always_comb begin
        if (hc1 != '0) begin
            hc_n   = hc1 - LEN_W'(1);
            found  = (hc1 == LEN_W'(1));
            best_n = best1;
        end else begin
            hc_n   = '0;
            found  = 1'b0;
            best_n = held;
        end
        peak_n = found ? (frames_reg - offset) : peak_frame_reg;
    end

    // Read addresses for the next frame step, from the pointers after this edge.
    assign pw_next      = step ? new_pw : pw_reg;
    assign hw_next      = step ? new_hw : hw_reg;
    assign prefix_raddr = pw_next + WIN_PTR_W'(2) - w_nx[WIN_PTR_W-1:0];
    assign hold_raddr   = hw_next + HOLD_PTR_W'(2) - h_nx[HOLD_PTR_W-1:0];

    // Ring storage; a read of the entry being written returns the new value.
    always_ff @(posedge aclk) begin
        if (step) begin
            prefix_mem[new_pw] <= sum;
            hold_mem[new_hw]   <= wsum;
        end
        if (step && (new_pw == prefix_raddr)) begin
            prefix_rd_reg <= sum;
        end else begin
            prefix_rd_reg <= prefix_mem[prefix_raddr];
        end
        if (step && (new_hw == hold_raddr)) begin
            hold_rd_reg <= wsum;
        end else begin
            hold_rd_reg <= hold_mem[hold_raddr];
        end
    end

    // Control state, valid bits and configuration.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            win_len_reg       <= WINDOW_LENGTH_RST;
            hold_len_reg      <= HOLD_LENGTH_RST;
            in_valid_reg      <= 1'b0;
            frame_acc_reg     <= '0;
            last_prefix_reg   <= '0;
            pw_reg            <= '0;
            hw_reg            <= '0;
            best_reg          <= '0;
            hcount_reg        <= '0;
            frames_reg        <= '0;
            peak_frame_reg    <= '0;
            prefix_vld_reg    <= '0;
            hold_vld_reg      <= '0;
            prefix_rd_vld_reg <= 1'b0;
            hold_rd_vld_reg   <= 1'b0;
            out_valid_reg     <= 1'b0;
        end else begin
            win_len_reg  <= win_len_next;
            hold_len_reg <= hold_len_next;

            // Input register and frame accumulator.
            if (s_fire) begin
                in_valid_reg  <= 1'b1;
                frame_acc_reg <= s_data.last_bin ? '0 : acc_plus_bin;
            end else if (consume) begin
                in_valid_reg <= 1'b0;
            end

            // Frame step.
            if (step) begin
                last_prefix_reg        <= sum;
                pw_reg                 <= new_pw;
                hw_reg                 <= new_hw;
                best_reg               <= best_n;
                hcount_reg             <= hc_n;
                frames_reg             <= frames_reg + DATA_W'(1);
                peak_frame_reg         <= peak_n;
                prefix_vld_reg[new_pw] <= 1'b1;
                hold_vld_reg[new_hw]   <= 1'b1;
            end

            prefix_rd_vld_reg <= (step && (new_pw == prefix_raddr))
                                 || prefix_vld_reg[prefix_raddr];
            hold_rd_vld_reg   <= (step && (new_hw == hold_raddr))
                                 || hold_vld_reg[hold_raddr];

            // Result register.
            if (step) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            in_total_reg <= acc_plus_bin;
            in_last_reg  <= s_data.last_bin;
        end
        if (step) begin
            out_reg.peak_found    <= found;
            out_reg.peak_position <= peak_n;
            out_reg.window_sum    <= wsum;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

endmodule

FILE: hw/rtl/mspd_checker.sv
module mspd_checker (
    input logic                              aclk,
    input logic                              aresetn,
    input logic                              s_ready,
    input logic                              m_valid,
    input logic                              m_ready,
    input mspd_pkg::mspd_out_t               m_data,
    input logic                              psel,
    input logic                              penable,
    input logic                              pwrite,
    input logic [mspd_pkg::ADDR_W-1:0]       paddr,
    input logic [mspd_pkg::PDATA_W-1:0]      pwdata,
    input logic [mspd_pkg::PDATA_W-1:0]      prdata,
    input logic                              pready
);
    import mspd_pkg::*;

    logic [DATA_W-1:0] last_pos_reg;

    // Peak position carried by the most recently delivered item.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_pos_reg <= '0;
        end else if (m_valid && m_ready) begin
            last_pos_reg <= m_data.peak_position;
        end
    end

    // After reset no result is pending and the input side is open.
    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> (!m_valid && s_ready))
        else $error("result pending or input blocked after reset");

    // A waiting result holds its payload.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_data)))
        else $error("result changed while stalled");

    // The peak position only moves on an item that confirms a peak.
    a_pos_steady: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_data.peak_found) |-> (m_data.peak_position == last_pos_reg))
        else $error("peak position changed without a peak");

    // A window length write reads back in the following cycle.
    a_cfg_readback: assert property (@(posedge aclk) disable iff (!aresetn)
        (psel && penable && pwrite && pready && (paddr[ADDR_W-1:2] == REG_WINDOW_LENGTH))
        |=> (!(psel && !pwrite && (paddr[ADDR_W-1:2] == REG_WINDOW_LENGTH))
             || (prdata == PDATA_W'($past(pwdata[LEN_W-1:0])))))
        else $error("window length read back wrong value");

endmodule

bind moving_sum_peak_detector mspd_checker u_mspd_checker (.*);
